### rtl/urlpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// urlpd_pkg
// Shared constants, types and hex helpers for the url percent decoder.
// ----------------------------------------------------------------------------
package urlpd_pkg;

   // character codes
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_0       = 8'h30;
   localparam logic [7:0] CHAR_9       = 8'h39;
   localparam logic [7:0] CHAR_UA      = 8'h41;
   localparam logic [7:0] CHAR_UF      = 8'h46;
   localparam logic [7:0] CHAR_LA      = 8'h61;
   localparam logic [7:0] CHAR_LF      = 8'h66;
   localparam logic [7:0] HEX_ALPHA_BASE = 8'd10;

   // escape phase codes
   localparam logic [1:0] PHASE_IDLE  = 2'd0;
   localparam logic [1:0] PHASE_PCT   = 2'd1;
   localparam logic [1:0] PHASE_DIGIT = 2'd2;

   // at most three decoded bytes come out of one input byte
   localparam int MAX_RESULTS = 3;
   localparam int CNT_W       = 2;

   typedef logic [7:0] byte_type;

   // decoded bytes of one input item
   typedef struct packed {
      byte_type [MAX_RESULTS-1:0] bytes;
      logic [CNT_W-1:0]           count;
      logic                       last;
   } urlpd_bundle_type;

   function automatic logic is_hex(input byte_type c);
      is_hex = ((c >= CHAR_0) && (c <= CHAR_9)) ||
               ((c >= CHAR_UA) && (c <= CHAR_UF)) ||
               ((c >= CHAR_LA) && (c <= CHAR_LF));
   endfunction

   function automatic logic [3:0] hex_nibble(input byte_type c);
      byte_type v;
      v = 8'h00;
      if ((c >= CHAR_0) && (c <= CHAR_9)) begin
         v = c - CHAR_0;
      end else if ((c >= CHAR_UA) && (c <= CHAR_UF)) begin
         v = c - CHAR_UA + HEX_ALPHA_BASE;
      end else if ((c >= CHAR_LA) && (c <= CHAR_LF)) begin
         v = c - CHAR_LA + HEX_ALPHA_BASE;
      end
      hex_nibble = v[3:0];
   endfunction

endpackage
`default_nettype wire

### rtl/url_percent_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// url_percent_decoder_core
// Streaming url percent decoder with plus as space, one encoded byte in,
// zero to three decoded bytes out.
// ----------------------------------------------------------------------------
//  channel | ports                          | direction
//  --------+--------------------------------+----------
//  request | req_valid req_ready req_byte   | in
//          | req_last                       |
//  result  | rsp_valid rsp_ready rsp_byte   | out
//          | rsp_last                       |
//
//  One item is taken per cycle while req_ready is high; its decoded bytes
//  are registered as a group in the result buffer and leave one byte per
//  cycle while rsp_ready is high. One-result items run at one per cycle; an item
//  with two or three results holds the request side until its last byte leaves.
//  Items yielding no result update the escape state and never touch the buffer.
//  Reset is synchronous and clears the escape state and the buffer.
// ----------------------------------------------------------------------------
module url_percent_decoder_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire urlpd_pkg::byte_type  req_byte,
   input  wire logic                 req_last,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output urlpd_pkg::byte_type       rsp_byte,
   output logic                      rsp_last
);
   import urlpd_pkg::*;

   urlpd_bundle_type           bundle;
   logic                       req_fire, rsp_fire, load, final_pos;
   byte_type [MAX_RESULTS-1:0] bytes_ff, bytes_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in, pos_ff, pos_in;
   logic                       last_ff, last_in, valid_ff, valid_in;

   // decode stage
   urlpd_decode u_decode (
      .clock  (clock),
      .reset  (reset),
      .in_byte(req_byte),
      .in_last(req_last),
      .take   (req_fire),
      .bundle (bundle)
   );

   // handshake
   assign final_pos = (pos_ff == (cnt_ff - 2'd1));
   assign req_ready = !valid_ff || (rsp_ready && final_pos);
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = valid_ff && rsp_ready;
   assign load      = req_fire && (bundle.count != '0);

   // result buffer next state
   always_comb begin
      bytes_in = bytes_ff;
      cnt_in   = cnt_ff;
      pos_in   = pos_ff;
      last_in  = last_ff;
      valid_in = valid_ff;
      if (load) begin
         bytes_in = bundle.bytes;
         cnt_in   = bundle.count;
         last_in  = bundle.last;
         pos_in   = '0;
         valid_in = 1'b1;
      end else if (rsp_fire) begin
         if (final_pos) begin
            valid_in = 1'b0;
         end else begin
            pos_in = pos_ff + 2'd1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pos_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         pos_ff   <= pos_in;
         cnt_ff   <= cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
      last_ff  <= last_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_byte  = bytes_ff[pos_ff];
   assign rsp_last  = valid_ff && last_ff && final_pos;

endmodule
`default_nettype wire

### rtl/urlpd_decode.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// urlpd_decode
// Escape state and the single-pass decode of one input byte into up to three
// output bytes.
// ----------------------------------------------------------------------------
module urlpd_decode (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire urlpd_pkg::byte_type        in_byte,
   input  wire logic                       in_last,
   input  wire logic                       take,
   output urlpd_pkg::urlpd_bundle_type     bundle
);
   import urlpd_pkg::*;

   logic [1:0]       phase_ff, phase_in;
   byte_type         held_ff, held_in;
   byte_type [MAX_RESULTS-1:0] slots;
   logic [CNT_W-1:0] cnt;
   logic             fresh;

   // decode of the current byte against the pending escape
   always_comb begin
      phase_in = phase_ff;
      held_in  = held_ff;
      slots    = '0;
      cnt      = '0;
      fresh    = 1'b0;

      unique case (phase_ff)
         PHASE_PCT: begin
            if (is_hex(in_byte)) begin
               held_in  = in_byte;
               phase_in = PHASE_DIGIT;
            end else begin
               slots[0] = CHAR_PERCENT;
               cnt      = 2'd1;
               fresh    = 1'b1;
            end
         end
         PHASE_DIGIT: begin
            if (is_hex(in_byte)) begin
               slots[0] = {hex_nibble(held_ff), hex_nibble(in_byte)};
               cnt      = 2'd1;
               phase_in = PHASE_IDLE;
            end else begin
               slots[0] = CHAR_PERCENT;
               slots[1] = held_ff;
               cnt      = 2'd2;
               fresh    = 1'b1;
            end
         end
         default: begin
            fresh = 1'b1;
         end
      endcase

      // byte handled with no escape pending
      if (fresh) begin
         if (in_byte == CHAR_PERCENT) begin
            phase_in = PHASE_PCT;
         end else begin
            slots[cnt] = (in_byte == CHAR_PLUS) ? CHAR_SPACE : in_byte;
            cnt        = cnt + 2'd1;
            phase_in   = PHASE_IDLE;
         end
      end

      // end of string flushes an open escape literally
      if (in_last) begin
         if ((phase_in == PHASE_PCT) || (phase_in == PHASE_DIGIT)) begin
            slots[cnt] = CHAR_PERCENT;
            cnt        = cnt + 2'd1;
         end
         if (phase_in == PHASE_DIGIT) begin
            slots[cnt] = held_in;
            cnt        = cnt + 2'd1;
         end
         phase_in = PHASE_IDLE;
         held_in  = '0;
      end
   end

   assign bundle.bytes = slots;
   assign bundle.count = cnt;
   assign bundle.last  = in_last;

   // escape state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_IDLE;
         held_ff  <= '0;
      end else if (take) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

endmodule
`default_nettype wire

### rtl/urlpd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// urlpd_checker
// Port level checks for the url percent decoder, bound to the top level.
// ----------------------------------------------------------------------------
module urlpd_checker (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire urlpd_pkg::byte_type req_byte,
   input wire logic                req_last,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire urlpd_pkg::byte_type rsp_byte,
   input wire logic                rsp_last
);
   import urlpd_pkg::*;

   // a stalled result item holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_byte) && $stable(rsp_last))
      else $error("result item changed while stalled");

   // buffer is empty after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // request side only stalls behind a waiting result
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request stalled with empty result buffer");

   // a plain final byte accepted with nothing queued fills the result buffer
   a_plain_last: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid && req_last && !is_hex(req_byte) &&
      (req_byte != CHAR_PERCENT) && (req_byte != CHAR_PLUS)
      |=> rsp_valid)
      else $error("final item produced no result");

endmodule

bind url_percent_decoder_core urlpd_checker u_urlpd_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .req_byte (req_byte),
   .req_last (req_last),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_byte (rsp_byte),
   .rsp_last (rsp_last)
);
`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for url_percent_decoder_core. A short table of encoded
// strings is followed by random strings of valid and broken escapes, plus signs
// and noise, with random gaps on the request and result sides. Each decoded byte
// is compared with a typed-in expectation or a decoder model kept in the bench.
// ---------------------------------------------------------------------------
module tb_top;
   import urlpd_pkg::*;

   localparam int         CLK_HALF     = 4;
   localparam int         RESET_CYCLES = 7;
   localparam int         RANDOM_ITEMS = 285;
   localparam int         MAX_GAP      = 4;
   localparam int         DRAIN_CYCLES = 10;
   localparam int         CYCLE_LIMIT  = 60000;
   localparam int         MAX_REPORTS  = 10;
   localparam logic [4:0] NOT_HEX      = 5'd16;

   // one decoded byte as it leaves the block
   typedef struct packed {
      byte_type data;
      logic     last;
   } decoded_type;

   // one encoded item, with an optional hand-written expectation
   typedef struct packed {
      byte_type       data;
      logic           last;
      logic           fixed;
      logic [1:0]     n;
      byte_type [2:0] outs;
   } enc_item_type;

   logic     clock     = 1'b0;
   logic     reset     = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_ready;
   byte_type req_byte  = '0;
   logic     req_last  = 1'b0;
   logic     rsp_valid;
   logic     rsp_ready = 1'b0;
   byte_type rsp_byte;
   logic     rsp_last;

   enc_item_type string_q [$];
   enc_item_type inflight_q [$];
   decoded_type  decoded_q [$];
   int           errors      = 0;
   int           cycle_count = 0;

   // decoder model state
   logic [1:0] esc_phase  = PHASE_IDLE;
   byte_type   held_digit = '0;

   url_percent_decoder_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_byte  (req_byte),
      .req_last  (req_last),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_byte  (rsp_byte),
      .rsp_last  (rsp_last)
   );

   // clock
   initial begin
      forever #CLK_HALF clock = ~clock;
   end

   // value of a hex character, NOT_HEX for anything else
   function automatic logic [4:0] hex_of(input byte_type c);
      byte_type v;
      v = {3'b000, NOT_HEX};
      if (c >= CHAR_0 && c <= CHAR_9) begin
         v = c - CHAR_0;
      end else if (c >= CHAR_UA && c <= CHAR_UF) begin
         v = c - CHAR_UA + 8'd10;
      end else if (c >= CHAR_LA && c <= CHAR_LF) begin
         v = c - CHAR_LA + 8'd10;
      end
      return v[4:0];
   endfunction

   // decode one encoded byte, updating the model state
   function automatic int decode_byte(input byte_type c, input logic fin,
                                      output decoded_type res [3]);
      int         n;
      logic       fresh;
      logic [4:0] hi;
      logic [4:0] lo;
      n = 0;
      fresh = 1'b0;
      for (int i = 0; i < 3; i++) res[i] = '{8'h00, 1'b0};
      case (esc_phase)
         PHASE_PCT: begin
            if (hex_of(c) != NOT_HEX) begin
               held_digit = c;
               esc_phase = PHASE_DIGIT;
            end else begin
               res[n] = '{CHAR_PERCENT, 1'b0};
               n++;
               esc_phase = PHASE_IDLE;
               fresh = 1'b1;
            end
         end
         PHASE_DIGIT: begin
            lo = hex_of(c);
            if (lo != NOT_HEX) begin
               hi = hex_of(held_digit);
               res[n] = '{{hi[3:0], lo[3:0]}, 1'b0};
               n++;
               esc_phase = PHASE_IDLE;
            end else begin
               res[n] = '{CHAR_PERCENT, 1'b0};
               res[n+1] = '{held_digit, 1'b0};
               n += 2;
               esc_phase = PHASE_IDLE;
               fresh = 1'b1;
            end
         end
         // idle, and the unused phase code
         default: begin
            esc_phase = PHASE_IDLE;
            fresh = 1'b1;
         end
      endcase
      // byte handled with no escape pending
      if (fresh) begin
         if (c == CHAR_PERCENT) begin
            esc_phase = PHASE_PCT;
         end else begin
            res[n] = '{(c == CHAR_PLUS) ? CHAR_SPACE : c, 1'b0};
            n++;
         end
      end
      // end of string flushes an open escape literally
      if (fin) begin
         if (esc_phase == PHASE_PCT || esc_phase == PHASE_DIGIT) begin
            res[n] = '{CHAR_PERCENT, 1'b0};
            n++;
         end
         if (esc_phase == PHASE_DIGIT) begin
            res[n] = '{held_digit, 1'b0};
            n++;
         end
         esc_phase = PHASE_IDLE;
         held_digit = '0;
         if (n > 0) res[n-1].last = 1'b1;
      end
      return n;
   endfunction

   function automatic byte_type rand_hex();
      int r;
      r = $urandom_range(0, 21);
      if (r < 10) return CHAR_0 + 8'(r);
      if (r < 16) return CHAR_UA + 8'(r - 10);
      return CHAR_LA + 8'(r - 16);
   endfunction

   task automatic add_row(input byte_type c, input logic fin, input logic fixed,
                          input int n, input byte_type o0 = 8'h00,
                          input byte_type o1 = 8'h00, input byte_type o2 = 8'h00);
      enc_item_type row;
      row = '{c, fin, fixed, 2'(n), {o2, o1, o0}};
      string_q.insert(string_q.size(), row);
   endtask

   task automatic report_error(input string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("mismatch: %s", msg);
   endtask

   // directed strings, expectations typed in where obvious
   task automatic build_directed();
      add_row(8'h61, 1'b1, 1'b1, 1, 8'h61);
      add_row(CHAR_PLUS, 1'b1, 1'b1, 1, CHAR_SPACE);
      add_row(8'h00, 1'b0, 1'b1, 1, 8'h00);
      add_row(8'hFF, 1'b0, 1'b1, 1, 8'hFF);
      add_row(CHAR_PERCENT, 1'b0, 1'b1, 0);
      add_row("4", 1'b0, 1'b1, 0);
      add_row("1", 1'b1, 1'b1, 1, 8'h41);
      add_row(CHAR_PERCENT, 1'b0, 1'b1, 0);
      add_row("f", 1'b0, 1'b1, 0);
      add_row("F", 1'b0, 1'b1, 1, 8'hFF);
      add_row(CHAR_PERCENT, 1'b0, 1'b1, 0);
      add_row("0", 1'b0, 1'b1, 0);
      add_row("0", 1'b1, 1'b1, 1, 8'h00);
      // non-hex after percent, plus still turns into a space
      add_row(CHAR_PERCENT, 1'b0, 1'b0, 0);
      add_row(CHAR_PLUS, 1'b0, 1'b0, 0);
      // a held percent starts a new escape
      add_row(CHAR_PERCENT, 1'b0, 1'b0, 0);
      add_row(CHAR_PERCENT, 1'b0, 1'b0, 0);
      add_row("2", 1'b0, 1'b0, 0);
      add_row("B", 1'b0, 1'b0, 0);
      // bad second digit releases percent and the held digit
      add_row(CHAR_PERCENT, 1'b0, 1'b0, 0);
      add_row("A", 1'b0, 1'b0, 0);
      add_row("g", 1'b1, 1'b0, 0);
      // lone percent as final byte
      add_row(CHAR_PERCENT, 1'b1, 1'b1, 1, CHAR_PERCENT);
      // open escape flushed by a final percent
      add_row(CHAR_PERCENT, 1'b0, 1'b0, 0);
      add_row("9", 1'b0, 1'b0, 0);
      add_row(CHAR_PERCENT, 1'b1, 1'b0, 0);
   endtask

   // random strings, valid escapes mixed with broken ones, lone percents, plus and noise
   task automatic build_random();
      byte_type s [$];
      byte_type odd [8];
      int       target;
      int       len;
      int       pick;
      odd = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67, CHAR_PERCENT, CHAR_PLUS};
      target = string_q.size() + RANDOM_ITEMS;
      while (string_q.size() < target) begin
         s.delete();
         len = $urandom_range(1, 6);
         repeat (len) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
               s.insert(s.size(), CHAR_PERCENT);
               s.insert(s.size(), rand_hex());
               s.insert(s.size(), rand_hex());
            end else if (pick < 50) begin
               s.insert(s.size(), CHAR_PLUS);
            end else if (pick < 60) begin
               s.insert(s.size(), CHAR_PERCENT);
               if ($urandom_range(0, 1) == 1) s.insert(s.size(), rand_hex());
               if ($urandom_range(0, 1) == 1) begin
                  s.insert(s.size(), odd[$urandom_range(0, 7)]);
               end else begin
                  s.insert(s.size(), 8'($urandom_range(0, 255)));
               end
            end else if (pick < 65) begin
               s.insert(s.size(), CHAR_PERCENT);
            end else begin
               s.insert(s.size(), 8'($urandom_range(0, 255)));
            end
         end
         foreach (s[i]) add_row(s[i], i == s.size() - 1, 1'b0, 0);
      end
   endtask

   // request side: strings go in with random gaps
   initial begin : stimulus
      enc_item_type it;
      int           gap;
      logic         calm;
      calm = 1'b0;
      build_directed();
      build_random();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      foreach (string_q[k]) begin
         it = string_q[k];
         if ($urandom_range(0, 15) == 0) calm = ~calm;
         gap = calm ? 0 : $urandom_range(0, MAX_GAP);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_byte  <= it.data;
         req_last  <= it.last;
         inflight_q.insert(inflight_q.size(), it);
         do @(posedge clock); while (!req_ready);
      end
      req_valid <= 1'b0;
      // wait out every expected byte, then watch for strays
      while (inflight_q.size() != 0 || decoded_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && decoded_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // result side: random stalls with calm stretches
   initial begin : sink
      int   gap;
      logic calm;
      calm = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0) calm = ~calm;
         gap = calm ? 0 : $urandom_range(0, MAX_GAP);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // predict on accepted items, check accepted results
   always @(posedge clock) begin : monitor
      decoded_type  res [3];
      decoded_type  got;
      decoded_type  want;
      enc_item_type it;
      int           n;
      if (!reset) begin
         if (req_valid && req_ready) begin
            it = inflight_q.pop_front();
            n = decode_byte(it.data, it.last, res);
            if (it.fixed) begin
               n = it.n;
               for (int i = 0; i < 3; i++) res[i] = '{it.outs[i], it.last && (i == n - 1)};
            end
            for (int i = 0; i < n; i++) decoded_q.insert(decoded_q.size(), res[i]);
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_byte, rsp_last};
            if (decoded_q.size() == 0) begin
               report_error($sformatf("unexpected byte %h last %b", got.data, got.last));
            end else begin
               want = decoded_q.pop_front();
               if (got.data != want.data || got.last != want.last) begin
                  report_error($sformatf("byte %h last %b, expected byte %h last %b",
                                         got.data, got.last, want.data, want.last));
               end
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

endmodule
